// ----- hdl/hbpe_pkg.sv -----
// shared types and constants of the huffman bit packing encoder
package hbpe_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int MAX_CODE_LEN = 32;
    localparam int CODE_W       = 32;
    localparam int LEN_W        = 6;
    localparam int SYM_W        = 8;
    localparam int TABLE_DEPTH  = 256;
    localparam int TABLE_ADDR_W = 8;
    localparam int PEND_W       = 7;
    localparam int PEND_CNT_W   = 3;
    localparam int ACC_W        = PEND_W + CODE_W;
    localparam int CNT_W        = 6;
    localparam int LEN_CAP      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_ENCODE = 2'd1;
    localparam logic [1:0] FUNC_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0]            out_byte;
        logic                  is_trailer;
        logic [PEND_CNT_W-1:0] pad_count;
        logic                  last;
    } pack_item_t;

    typedef struct packed {
        logic [1:0]        func;
        logic              hit;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  length;
    } lookup_t;

endpackage

// ----- hdl/hbpe_table.sv -----
// code table memory with entry valid bits and the lookup stage
module hbpe_table
    import hbpe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd,
    output logic      lk_valid,
    output lookup_t   lk,
    input  logic      lk_take
);

    logic [CODE_W+LEN_W-1:0] mem [TABLE_DEPTH];
    logic [CODE_W+LEN_W-1:0] rd_reg;
    logic [TABLE_DEPTH-1:0]  valid_reg;
    logic                    lk_valid_reg;
    logic                    lk_valid_next;
    logic [1:0]              func_reg;
    logic                    hit_reg;

    logic                    accept;
    logic                    in_range;
    logic [LEN_W-1:0]        len_sat;
    logic [TABLE_ADDR_W-1:0] addr;
    logic                    do_load;
    logic                    do_read;
    logic                    enter;

    assign cmd_stall = lk_valid_reg && !lk_take;
    assign accept    = cmd_valid && !cmd_stall;
    assign in_range  = int'(cmd.symbol) < SYMBOL_COUNT;
    assign len_sat   = (int'(cmd.code_length) > LEN_CAP) ? LEN_W'(LEN_CAP) : cmd.code_length;
    assign addr      = cmd.symbol[TABLE_ADDR_W-1:0];
    assign do_load   = accept && (cmd.func == FUNC_LOAD) && in_range;
    assign do_read   = accept && (cmd.func == FUNC_ENCODE);
    assign enter     = accept && ((cmd.func == FUNC_ENCODE) || (cmd.func == FUNC_FLUSH));

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            mem[addr] <= {cmd.code_bits, len_sat};
        end
        if (do_read)
        begin
            rd_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (do_load)
        begin
            valid_reg[addr] <= (len_sat != '0);
        end
    end

    always_comb
    begin
        lk_valid_next = lk_valid_reg;
        if (enter)
        begin
            lk_valid_next = 1'b1;
        end
        else if (lk_take)
        begin
            lk_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lk_valid_reg <= 1'b0;
        end
        else
        begin
            lk_valid_reg <= lk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enter)
        begin
            func_reg <= cmd.func;
            hit_reg  <= in_range && valid_reg[addr];
        end
    end

    assign lk_valid  = lk_valid_reg;
    assign lk.func   = func_reg;
    assign lk.hit    = hit_reg;
    assign lk.code   = rd_reg[CODE_W+LEN_W-1:LEN_W];
    assign lk.length = rd_reg[LEN_W-1:0];

endmodule

// ----- hdl/hbpe_packer.sv -----
// bit accumulator, byte emission, flush trailer and output register
module hbpe_packer
    import hbpe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       lk_valid,
    input  lookup_t    lk,
    output logic       lk_take,
    output logic       pack_valid,
    input  logic       pack_stall,
    output pack_item_t pack
);

    logic [ACC_W-1:0]      acc_reg;
    logic [ACC_W-1:0]      acc_next;
    logic [CNT_W-1:0]      total_reg;
    logic [CNT_W-1:0]      total_next;
    logic                  trailer_reg;
    logic                  trailer_next;
    logic [PEND_CNT_W-1:0] pad_reg;
    logic [PEND_CNT_W-1:0] pad_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    pack_item_t            out_reg;
    pack_item_t            out_next;

    logic                  out_free;
    logic                  emit_fire;
    logic                  trailer_fire;
    logic [CNT_W-1:0]      emit_shift;
    logic [CNT_W-1:0]      eff_total;
    logic [PEND_CNT_W-1:0] pend_cnt;
    logic [PEND_W-1:0]     pend_bits;
    logic [ACC_W-1:0]      code_mask;
    logic [ACC_W-1:0]      enc_acc;
    logic [CNT_W-1:0]      enc_total;
    logic [PEND_CNT_W-1:0] flush_pad;
    logic [7:0]            emit_byte;
    logic                  emit_last;

    assign out_free     = !out_valid_reg || !pack_stall;
    assign emit_fire    = out_free && (total_reg >= CNT_W'(8));
    assign trailer_fire = out_free && trailer_reg && (total_reg < CNT_W'(8));
    assign emit_shift   = total_reg - CNT_W'(8);
    assign eff_total    = emit_fire ? emit_shift : total_reg;
    assign lk_take      = lk_valid && (eff_total < CNT_W'(8)) && (!trailer_reg || trailer_fire);

    assign pend_cnt  = eff_total[PEND_CNT_W-1:0];
    assign pend_bits = acc_reg[PEND_W-1:0] & PEND_W'((8'd1 << pend_cnt) - 8'd1);
    assign code_mask = (ACC_W'(1) << lk.length) - ACC_W'(1);
    assign enc_acc   = (ACC_W'(pend_bits) << lk.length) | (ACC_W'(lk.code) & code_mask);
    assign enc_total = CNT_W'(pend_cnt) + CNT_W'(lk.length);
    assign flush_pad = PEND_CNT_W'(4'd8 - {1'b0, pend_cnt});
    assign emit_byte = 8'(acc_reg >> emit_shift);
    assign emit_last = (emit_shift < CNT_W'(8)) && !trailer_reg;

    always_comb
    begin
        acc_next     = acc_reg;
        total_next   = total_reg;
        trailer_next = trailer_reg;
        pad_next     = pad_reg;
        if (emit_fire)
        begin
            total_next = emit_shift;
        end
        if (trailer_fire)
        begin
            trailer_next = 1'b0;
        end
        if (lk_take)
        begin
            case (lk.func)
                FUNC_ENCODE:
                begin
                    if (lk.hit)
                    begin
                        acc_next   = enc_acc;
                        total_next = enc_total;
                    end
                end
                FUNC_FLUSH:
                begin
                    acc_next     = ACC_W'(pend_bits) << flush_pad;
                    total_next   = (pend_cnt == '0) ? '0 : CNT_W'(8);
                    trailer_next = 1'b1;
                    pad_next     = flush_pad;
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_free)
        begin
            out_valid_next = emit_fire || trailer_fire;
            if (emit_fire)
            begin
                out_next.out_byte   = emit_byte;
                out_next.is_trailer = 1'b0;
                out_next.pad_count  = '0;
                out_next.last       = emit_last;
            end
            else if (trailer_fire)
            begin
                out_next.out_byte   = '0;
                out_next.is_trailer = 1'b1;
                out_next.pad_count  = pad_reg;
                out_next.last       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            total_reg     <= '0;
            trailer_reg   <= 1'b0;
            pad_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            total_reg     <= total_next;
            trailer_reg   <= trailer_next;
            pad_reg       <= pad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign pack_valid = out_valid_reg;
    assign pack       = out_reg;

endmodule

// ----- hdl/huffman_bit_packing_encoder.sv -----
// top level of the huffman bit packing encoder
//
// cmd channel: one item per handshake, func selects load, encode or flush.
// a load writes one table entry at acceptance and gives no result.
// an encode looks its symbol up in the code table memory (registered read)
// and appends the code to the bit accumulator; each full byte leaves on the
// pack channel, first code bit in bit 7, last set on the final byte of the item.
// a flush emits the zero-padded partial byte, if any, then a trailer with
// the pad count, and empties the accumulator.
// the first result passes the lookup register, the accumulator and the pack register.
// throughput: one cmd item per cycle while items give no bytes; an item that
// gives several results holds the packer until done, since the single output
// register moves one byte per cycle unless stalled (up to four per encode).
// reset clears the entry valid bits and the accumulator; table contents stay
// undefined until loaded.
// while pack_stall is high the output item holds, the packer waits and
// cmd_stall rises once the lookup stage is full.
module huffman_bit_packing_encoder
    import hbpe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  cmd_item_t  cmd,
    output logic       pack_valid,
    input  logic       pack_stall,
    output pack_item_t pack
);

    logic    lk_valid;
    lookup_t lk;
    logic    lk_take;

    hbpe_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .lk_valid  (lk_valid),
        .lk        (lk),
        .lk_take   (lk_take)
    );

    hbpe_packer u_packer (
        .clk        (clk),
        .rst_n      (rst_n),
        .lk_valid   (lk_valid),
        .lk         (lk),
        .lk_take    (lk_take),
        .pack_valid (pack_valid),
        .pack_stall (pack_stall),
        .pack       (pack)
    );

    a_trailer_last: assert property (@(posedge clk) disable iff (!rst_n)
        pack_valid && pack.is_trailer |-> pack.last)
        else $error("trailer item without last");

    a_trailer_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pack_valid && pack.is_trailer |-> pack.out_byte == 8'd0)
        else $error("trailer item carries data");

    a_data_pad: assert property (@(posedge clk) disable iff (!rst_n)
        pack_valid && !pack.is_trailer |-> pack.pad_count == '0)
        else $error("data item carries pad count");

endmodule
